/* design/mq_binary_arithmetic_decoder_defines.svh */
// ------------------------------------------------------------------------
// MQ decoder assertion macros
// Shared property shorthands for the checker.
// ------------------------------------------------------------------------
`ifndef MQ_BINARY_ARITHMETIC_DECODER_DEFINES_SVH
`define MQ_BINARY_ARITHMETIC_DECODER_DEFINES_SVH

// same-cycle implication
`define MQD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mq decoder check failed");

// next-cycle implication
`define MQD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mq decoder check failed");

`endif

/* design/mqd_pkg.sv */
// ------------------------------------------------------------------------
// MQ decoder package
// Item types, action and status codes, probability tables.
// ------------------------------------------------------------------------
package mqd_pkg;

  localparam int NUM_CONTEXTS_DEF = 19;
  localparam int QUEUE_DEPTH_DEF  = 16;

  localparam logic [2:0] ACT_PUSH   = 3'd0;
  localparam logic [2:0] ACT_END    = 3'd1;
  localparam logic [2:0] ACT_START  = 3'd2;
  localparam logic [2:0] ACT_SET    = 3'd3;
  localparam logic [2:0] ACT_DECODE = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [5:0] LAST_STATE = 6'd46;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_value;
    logic [4:0] context_number;
    logic [5:0] init_state_index;
    logic       init_mps;
  } item_t;

  typedef struct packed {
    logic       decision;
    logic [1:0] status;
  } result_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EVAL   = 7'b0000010,
    S_SHIFT  = 7'b0000100,
    S_FETCH  = 7'b0001000,
    S_BYTE   = 7'b0010000,
    S_COMMIT = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  localparam logic [15:0] QE_ROM [47] = '{
    16'h5601, 16'h3401, 16'h1801, 16'h0AC1, 16'h0521, 16'h0221, 16'h5601, 16'h5401,
    16'h4801, 16'h3801, 16'h3001, 16'h2401, 16'h1C01, 16'h1601, 16'h5601, 16'h5401,
    16'h5101, 16'h4801, 16'h3801, 16'h3401, 16'h3001, 16'h2801, 16'h2401, 16'h2201,
    16'h1C01, 16'h1801, 16'h1601, 16'h1401, 16'h1201, 16'h1101, 16'h0AC1, 16'h09C1,
    16'h08A1, 16'h0521, 16'h0441, 16'h02A1, 16'h0221, 16'h0141, 16'h0111, 16'h0085,
    16'h0049, 16'h0025, 16'h0015, 16'h0009, 16'h0005, 16'h0001, 16'h5601};

  localparam logic [5:0] NMPS_ROM [47] = '{
    6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd38, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12,
    6'd13, 6'd29, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34,
    6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45,
    6'd45, 6'd46};

  localparam logic [5:0] NLPS_ROM [47] = '{
    6'd1, 6'd6, 6'd9, 6'd12, 6'd29, 6'd33, 6'd6, 6'd14, 6'd14, 6'd14, 6'd17, 6'd18,
    6'd20, 6'd21, 6'd14, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd19, 6'd20,
    6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31,
    6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42,
    6'd43, 6'd46};

  localparam logic [46:0] SWITCH_ROM = 47'h0000_0000_4041;

endpackage

/* design/mq_binary_arithmetic_decoder.sv */
// ------------------------------------------------------------------------
// MQ binary arithmetic decoder
// Context-adaptive MQ decoder with a compressed-byte queue.
// ------------------------------------------------------------------------
// One item at a time. Push, end mark, set-context and unused actions go
// from idle straight to the done state. A decode is a context memory read,
// then the shift loop, each byte brought in being an idle shift step and a
// read of the queue memory, then a commit. A start brings in two bytes.
// Context state lives in one memory, compressed bytes in another; all
// register updates are held until the item completes, so an item that
// runs the queue dry leaves everything unchanged. The result register lets
// the next item in while a result waits.
module mq_binary_arithmetic_decoder #(
  parameter int NUM_CONTEXTS = mqd_pkg::NUM_CONTEXTS_DEF,
  parameter int QUEUE_DEPTH  = mqd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  mqd_pkg::item_t  item,
  output logic            result_valid,
  input  logic            result_stall,
  output mqd_pkg::result_t result
);
  import mqd_pkg::*;

  localparam int CW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int FW = QW + 1;
  localparam int SW = QW + 2;
  localparam logic [FW-1:0] QD_F = FW'(QUEUE_DEPTH);
  localparam logic [SW-1:0] QD_S = SW'(QUEUE_DEPTH);

  state_t state;

  // committed coder state
  logic [15:0] interval_a;
  logic [31:0] code_c;
  logic [3:0]  bit_count;
  logic [7:0]  last_byte;
  logic        end_seen;
  logic [QW-1:0] head;
  logic [FW-1:0] fill;
  logic [NUM_CONTEXTS-1:0] ctx_valid;

  // working copies
  logic [15:0] wa;
  logic [31:0] wc;
  logic [3:0]  wct;
  logic [7:0]  wb;
  logic [FW-1:0] wpos;
  logic [4:0]  guard;
  logic        is_start;
  logic        start_first;
  logic        from_q;
  logic        ctx_vld;
  logic [CW-1:0] cx;
  logic        dec_d;
  logic [5:0]  new_idx;
  logic        new_mps;
  result_t     pend;

  // memories
  logic          ctx_we;
  logic [CW-1:0] ctx_waddr;
  logic [6:0]    ctx_wdata;
  logic [CW-1:0] ctx_raddr;
  logic [6:0]    ctx_rdata;
  logic          q_we;
  logic [QW-1:0] q_waddr;
  logic [QW-1:0] q_raddr;
  logic [7:0]    q_rdata;

  mqd_ram #(.WIDTH(7), .DEPTH(NUM_CONTEXTS)) u_ctx_ram (
    .clk(clk), .we(ctx_we), .waddr(ctx_waddr), .wdata(ctx_wdata),
    .raddr(ctx_raddr), .rdata(ctx_rdata)
  );

  mqd_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(item.byte_value),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  logic          accept;
  logic          cx_ok;
  logic [SW-1:0] rd_sum;
  logic [SW-1:0] wr_sum;
  logic [5:0]    set_idx;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign cx_ok      = int'(item.context_number) < NUM_CONTEXTS;
  assign ctx_raddr  = CW'(item.context_number);
  assign set_idx    = (item.init_state_index > LAST_STATE) ? LAST_STATE
                                                           : item.init_state_index;

  // ring addresses; sums stay below twice the depth
  always_comb begin
    rd_sum  = SW'(head) + SW'(wpos);
    wr_sum  = SW'(head) + SW'(fill);
    q_raddr = (rd_sum >= QD_S) ? QW'(rd_sum - QD_S) : QW'(rd_sum);
    q_waddr = (wr_sum >= QD_S) ? QW'(wr_sum - QD_S) : QW'(wr_sum);
  end

  assign q_we = accept && (item.action == ACT_PUSH) && (fill < QD_F);

  always_comb begin
    ctx_we    = 1'b0;
    ctx_waddr = ctx_raddr;
    ctx_wdata = {set_idx, item.init_mps};
    if (accept && item.action == ACT_SET && cx_ok) begin
      ctx_we = 1'b1;
    end else if (state == S_COMMIT && !is_start) begin
      ctx_we    = 1'b1;
      ctx_waddr = cx;
      ctx_wdata = {new_idx, new_mps};
    end
  end

  // decode evaluation, from the context read
  logic [5:0]  e_idx_raw;
  logic [5:0]  e_idx;
  logic        e_mps;
  logic [15:0] e_qe;
  logic [15:0] e_av;
  logic [15:0] e_chigh;
  logic [15:0] e_a;
  logic [31:0] e_c;
  logic        e_lps;
  logic        e_renorm;

  always_comb begin
    e_idx_raw = ctx_vld ? ctx_rdata[6:1] : 6'd0;
    e_mps     = ctx_vld ? ctx_rdata[0] : 1'b0;
    e_idx     = (e_idx_raw > LAST_STATE) ? LAST_STATE : e_idx_raw;
    e_qe      = QE_ROM[e_idx];
    e_av      = interval_a - e_qe;
    e_chigh   = code_c[31:16];
    e_renorm  = 1'b1;
    e_c       = code_c;
    e_a       = e_av;
    if (e_chigh < e_av) begin
      if (e_av[15]) begin
        e_renorm = 1'b0;
        e_lps    = 1'b0;
      end else begin
        e_lps = (e_av < e_qe);
      end
    end else begin
      e_c   = {e_chigh - e_av, code_c[15:0]};
      e_lps = !(e_av < e_qe);
      e_a   = e_qe;
    end
  end

  // byte input step
  logic [7:0]    b1;
  logic [FW-1:0] b_next;
  logic [15:0]   s_a;

  assign b1     = from_q ? q_rdata : 8'hFF;
  assign b_next = wpos + FW'(from_q);
  assign s_a    = {wa[14:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      interval_a   <= 16'h8000;
      code_c       <= '0;
      bit_count    <= '0;
      last_byte    <= '0;
      end_seen     <= 1'b0;
      head         <= '0;
      fill         <= '0;
      ctx_valid    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            ctx_vld     <= ctx_valid[ctx_raddr];
            cx          <= ctx_raddr;
            is_start    <= (item.action == ACT_START);
            start_first <= (item.action == ACT_START);
            case (item.action)
              ACT_PUSH: begin
                if (fill < QD_F) begin
                  fill <= fill + FW'(1);
                  pend <= '{decision: 1'b0, status: ST_OK};
                end else begin
                  pend <= '{decision: 1'b0, status: ST_FULL};
                end
                state <= S_DONE;
              end
              ACT_END: begin
                end_seen <= 1'b1;
                pend     <= '{decision: 1'b0, status: ST_OK};
                state    <= S_DONE;
              end
              ACT_START: begin
                wpos  <= '0;
                wct   <= '0;
                state <= S_FETCH;
              end
              ACT_SET: begin
                if (cx_ok) begin
                  ctx_valid[ctx_raddr] <= 1'b1;
                end
                pend  <= '{decision: 1'b0, status: ST_OK};
                state <= S_DONE;
              end
              ACT_DECODE: begin
                pend  <= '{decision: 1'b0, status: ST_OK};
                state <= cx_ok ? S_EVAL : S_DONE;
              end
              default: begin
                pend  <= '{decision: 1'b0, status: ST_OK};
                state <= S_DONE;
              end
            endcase
          end
        end
        S_EVAL: begin
          wa    <= e_a;
          wc    <= e_c;
          wct   <= bit_count;
          wb    <= last_byte;
          wpos  <= '0;
          guard <= '0;
          if (e_lps) begin
            dec_d   <= !e_mps;
            new_mps <= SWITCH_ROM[e_idx] ? !e_mps : e_mps;
            new_idx <= NLPS_ROM[e_idx];
          end else begin
            dec_d   <= e_mps;
            new_mps <= e_mps;
            new_idx <= e_renorm ? NMPS_ROM[e_idx] : e_idx;
          end
          state <= e_renorm ? S_SHIFT : S_COMMIT;
        end
        S_SHIFT: begin
          if (wct == 4'd0) begin
            state <= S_FETCH;
          end else begin
            wa    <= s_a;
            wc    <= {wc[30:0], 1'b0};
            wct   <= wct - 4'd1;
            guard <= guard + 5'd1;
            if (s_a[15] || s_a == 16'd0 || guard >= 5'd15) begin
              state <= S_COMMIT;
            end
          end
        end
        S_FETCH: begin
          if (wpos < fill) begin
            from_q <= 1'b1;
            state  <= S_BYTE;
          end else if (end_seen) begin
            from_q <= 1'b0;
            state  <= S_BYTE;
          end else begin
            pend  <= '{decision: 1'b0, status: ST_EMPTY};
            state <= S_DONE;
          end
        end
        S_BYTE: begin
          if (start_first) begin
            start_first <= 1'b0;
            wb          <= b1;
            wc          <= {8'h00, b1 ^ 8'hFF, 16'h0000};
            wpos        <= b_next;
            state       <= S_FETCH;
          end else begin
            if (wb == 8'hFF) begin
              if (b1 > 8'h8F) begin
                wct <= 4'd8;
              end else begin
                wpos <= b_next;
                wb   <= b1;
                wc   <= wc + 32'h0000_FE00 - {15'd0, b1, 9'd0};
                wct  <= 4'd7;
              end
            end else begin
              wpos <= b_next;
              wb   <= b1;
              wc   <= wc + 32'h0000_FF00 - {16'd0, b1, 8'd0};
              wct  <= 4'd8;
            end
            state <= is_start ? S_COMMIT : S_SHIFT;
          end
        end
        S_COMMIT: begin
          head  <= q_raddr;
          fill  <= fill - wpos;
          last_byte <= wb;
          if (is_start) begin
            code_c     <= {wc[24:0], 7'd0};
            bit_count  <= wct - 4'd7;
            interval_a <= 16'h8000;
            pend       <= '{decision: 1'b0, status: ST_OK};
          end else begin
            code_c     <= wc;
            bit_count  <= wct;
            interval_a <= wa;
            ctx_valid[cx] <= 1'b1;
            pend       <= '{decision: dec_d, status: ST_OK};
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result <= pend;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/mqd_ram.sv */
// ------------------------------------------------------------------------
// MQ decoder RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ------------------------------------------------------------------------
module mqd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/mqd_checker.sv */
// ------------------------------------------------------------------------
// MQ decoder port checker
// Watches the top-level ports; bound to the decoder.
// ------------------------------------------------------------------------
`include "mq_binary_arithmetic_decoder_defines.svh"

module mqd_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input mqd_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input mqd_pkg::result_t result
);
  import mqd_pkg::*;

  logic in_xfer;
  assign in_xfer = item_valid && !item_stall;

  // a stalled result holds
  `MQD_ASSERT_NXT(a_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result))
  // one item in flight: the input closes right after a transfer
  `MQD_ASSERT_NXT(a_one_item, clk, rst, in_xfer, item_stall)
  // a decision only comes with success
  `MQD_ASSERT_IMP(a_dec_ok, clk, rst, result_valid && result.status != ST_OK, !result.decision)
  `MQD_ASSERT_IMP(a_status, clk, rst, result_valid,
                  result.status == ST_OK || result.status == ST_EMPTY || result.status == ST_FULL)

endmodule

bind mq_binary_arithmetic_decoder mqd_checker u_mqd_checker (.*);
